FILE: sv/bass_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bass_pkg
// shared types and constants of the advertising structure scanner
// ----------------------------------------------------------------------------
package bass_pkg;

    localparam int MaxPacketBytes = 255;
    localparam int PosW           = $clog2(MaxPacketBytes + 1);

    localparam logic [7:0] TypeFlags    = 8'h01;
    localparam logic [7:0] TypeTxPower  = 8'h0A;
    localparam logic [7:0] TypeAuxPtr   = 8'h1F;
    localparam logic [7:0] TypeAdi      = 8'h29;
    localparam logic [7:0] PowerDefault = 8'h7F;
    localparam logic [7:0] FlagCapMask  = 8'h04;
    localparam logic [7:0] FlagExtMask  = 8'h18;

    localparam int OutDataW = 16;

    typedef enum logic [1:0] {
        PH_LENGTH,
        PH_TYPE,
        PH_VALUE,
        PH_STOPPED
    } t_phase;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       end_of_packet;
    } t_in_item;

    typedef struct packed {
        logic [7:0] tx_power_raw;
        logic [1:0] adv_mode;
        logic       adi_seen;
        logic       aux_pointer_seen;
        logic       extended_seen;
    } t_result;

endpackage

FILE: sv/bass_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bass_in_reg
// input register: holds one accepted byte until the parser takes it
// ----------------------------------------------------------------------------
module bass_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_valid,
    output logic              o_s_ready,
    input  bass_pkg::t_in_item i_s_item,
    input  logic              i_adv,
    output logic              o_valid,
    output bass_pkg::t_in_item o_item
);
    import bass_pkg::*;

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;

    assign o_s_ready = !r_valid || i_adv;

    always_comb begin
        n_valid = r_valid;
        if (i_s_valid && o_s_ready) begin
            n_valid = 1'b1;
        end else if (i_adv) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_valid && o_s_ready) begin
            r_item <= i_s_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: sv/bass_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bass_parser
// length-type-value walk with pending effects, one byte per cycle while i_adv is high
// ----------------------------------------------------------------------------
module bass_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  bass_pkg::t_in_item i_item,
    output logic               o_res_valid,
    output bass_pkg::t_result  o_res
);
    import bass_pkg::*;

    t_phase          r_phase,  n_phase;
    logic [7:0]      r_len,    n_len;
    logic [7:0]      r_left,   n_left;
    logic [PosW-1:0] r_pos,    n_pos;
    logic [7:0]      r_type,   n_type;
    logic [7:0]      r_pval,   n_pval;
    logic            r_pvalid, n_pvalid;
    logic            r_aux,    n_aux;
    logic            r_adi,    n_adi;
    logic [1:0]      r_mode,   n_mode;
    logic [7:0]      r_power,  n_power;
    logic            r_ext,    n_ext;

    logic       c_commit;
    logic [7:0] c_type;
    logic [7:0] c_idx;
    logic [7:0] c_byte;

    assign c_byte = i_item.payload_byte;
    assign c_idx  = r_len - 8'd1 - r_left;

    always_comb begin
        n_phase  = r_phase;
        n_len    = r_len;
        n_left   = r_left;
        n_pos    = r_pos;
        n_type   = r_type;
        n_pval   = r_pval;
        n_pvalid = r_pvalid;
        n_aux    = r_aux;
        n_adi    = r_adi;
        n_mode   = r_mode;
        n_power  = r_power;
        n_ext    = r_ext;
        c_commit = 1'b0;
        c_type   = r_type;
        o_res    = '0;

        if (r_pos < PosW'(MaxPacketBytes)) begin
            n_pos = r_pos + 1'b1;
            case (r_phase)
                PH_LENGTH: begin
                    n_len   = c_byte;
                    n_phase = (c_byte == 8'd0) ? PH_STOPPED : PH_TYPE;
                end
                PH_TYPE: begin
                    c_type   = c_byte;
                    n_type   = c_byte;
                    n_left   = r_len - 8'd1;
                    n_pval   = '0;
                    n_pvalid = 1'b0;
                    if (n_left == 8'd0) begin
                        c_commit = 1'b1;
                    end else begin
                        n_phase = PH_VALUE;
                    end
                end
                PH_VALUE: begin
                    if (((r_type == TypeTxPower || r_type == TypeFlags) && c_idx == 8'd0) ||
                        (r_type == TypeAdi && c_idx == 8'd1)) begin
                        n_pval   = c_byte;
                        n_pvalid = 1'b1;
                    end
                    n_left = r_left - 8'd1;
                    if (n_left == 8'd0) begin
                        c_commit = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        // structure complete: apply its held effect
        if (c_commit) begin
            case (c_type)
                TypeAuxPtr: begin
                    n_aux = 1'b1;
                    n_ext = 1'b1;
                end
                TypeAdi: begin
                    n_adi = 1'b1;
                    n_ext = 1'b1;
                    if (n_pvalid) begin
                        n_mode = n_pval[1:0];
                    end
                end
                TypeTxPower: begin
                    if (n_pvalid) begin
                        n_power = n_pval;
                    end
                end
                TypeFlags: begin
                    if (n_pvalid && |(n_pval & FlagCapMask) && |(n_pval & FlagExtMask)) begin
                        n_ext = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            n_pvalid = 1'b0;
            n_pval   = '0;
            n_phase  = PH_LENGTH;
        end

        o_res.extended_seen    = n_ext;
        o_res.aux_pointer_seen = n_aux;
        o_res.adi_seen         = n_adi;
        o_res.adv_mode         = n_mode;
        o_res.tx_power_raw     = n_power;

        // end of packet: result goes out, scan state starts over
        if (i_item.end_of_packet) begin
            n_phase  = PH_LENGTH;
            n_len    = '0;
            n_left   = '0;
            n_pos    = '0;
            n_type   = '0;
            n_pval   = '0;
            n_pvalid = 1'b0;
            n_aux    = 1'b0;
            n_adi    = 1'b0;
            n_mode   = '0;
            n_power  = PowerDefault;
            n_ext    = 1'b0;
        end
    end

    assign o_res_valid = i_adv && i_item.end_of_packet;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_LENGTH;
            r_len    <= '0;
            r_left   <= '0;
            r_pos    <= '0;
            r_type   <= '0;
            r_pval   <= '0;
            r_pvalid <= 1'b0;
            r_aux    <= 1'b0;
            r_adi    <= 1'b0;
            r_mode   <= '0;
            r_power  <= PowerDefault;
            r_ext    <= 1'b0;
        end else if (i_adv) begin
            r_phase  <= n_phase;
            r_len    <= n_len;
            r_left   <= n_left;
            r_pos    <= n_pos;
            r_type   <= n_type;
            r_pval   <= n_pval;
            r_pvalid <= n_pvalid;
            r_aux    <= n_aux;
            r_adi    <= n_adi;
            r_mode   <= n_mode;
            r_power  <= n_power;
            r_ext    <= n_ext;
        end
    end

endmodule

FILE: sv/bass_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bass_out_reg
// result register holding one packet summary until the receiver takes it
// ----------------------------------------------------------------------------
module bass_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  bass_pkg::t_result i_res,
    input  logic              i_m_ready,
    output logic              o_m_valid,
    output logic              o_free,
    output bass_pkg::t_result o_res
);
    import bass_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    assign o_free = !r_valid || i_m_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_m_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_m_valid = r_valid;
    assign o_res     = r_res;

endmodule

FILE: sv/ble_adv_structure_scanner_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ble_adv_structure_scanner_unit
// scans advertising payload structures and reports one summary per packet
// ----------------------------------------------------------------------------
// usage:
//   slave stream: one payload byte per transaction on s_axis_tdata, tlast on
//   the final byte of the packet. a byte is taken every cycle as long as the
//   input register is empty or its byte can move on.
//   master stream: one summary transaction per packet, 16-bit tdata.
//   output path: the tlast byte passes the input register, then its summary
//   is loaded into the result register.
//   throughput: one byte per cycle while no tlast byte is held; the single
//   parse pass between the input and state registers sets that figure.
//   stall: bytes without tlast keep flowing while a summary waits; a tlast
//   byte waits in the input register until the result register is free, and
//   meanwhile the slave side stops taking bytes.
//   reset: both registers empty, scan state at start of packet, tx power
//   default 0x7F.
// ----------------------------------------------------------------------------
module ble_adv_structure_scanner_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // payload_byte
    input  logic        i_s_axis_tlast,   // end_of_packet
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // extended_seen, aux_pointer_seen, adi_seen, adv_mode[1:0],
    // tx_power_raw[7:0], zero pad
    output logic [bass_pkg::OutDataW-1:0] o_m_axis_tdata
);
    import bass_pkg::*;

    t_in_item w_s_item;
    t_in_item w_item;
    logic     w_in_valid;
    logic     w_adv;
    logic     w_free;
    logic     w_res_valid;
    t_result  w_res;
    t_result  w_out_res;

    assign w_s_item.payload_byte  = i_s_axis_tdata;
    assign w_s_item.end_of_packet = i_s_axis_tlast;

    // a tlast byte only moves on when the result register can take its summary
    assign w_adv = w_in_valid && (!w_item.end_of_packet || w_free);

    bass_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .i_s_item  (w_s_item),
        .i_adv     (w_adv),
        .o_valid   (w_in_valid),
        .o_item    (w_item)
    );

    bass_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_adv),
        .i_item      (w_item),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    bass_out_reg u_out_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_res_valid),
        .i_res     (w_res),
        .i_m_ready (i_m_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .o_free    (w_free),
        .o_res     (w_out_res)
    );

    assign o_m_axis_tdata = {{(OutDataW - $bits(t_result)){1'b0}}, w_out_res};

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("summary loaded over a pending one");

    a_res_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> (w_in_valid && w_item.end_of_packet))
        else $error("summary without a tlast byte");

    a_res_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |=> o_m_axis_tvalid)
        else $error("summary not presented after load");

    a_hold_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_valid && !w_adv) |=> (w_in_valid && $stable(w_item)))
        else $error("stalled byte lost from input register");

endmodule
